FILE: design/tsp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsp_pkg
// Shared widths, reset values, register indexes and the command and status
// words that pass between the slice planner controller and datapath.
// ----------------------------------------------------------------------------
package tsp_pkg;

   localparam int ITEM_BITS      = 24;
   localparam int FIELD_BITS     = 24;
   localparam int BUDGET_BITS    = 48;
   localparam int LIMIT_BITS     = 6;
   localparam int MADE_BITS      = 7;
   localparam int MAX_RESULTS    = 64;
   localparam int CSR_INDEX_BITS = 1;

   localparam int TRI_BITS  = 2 * ITEM_BITS;
   localparam int CMP_BITS  = (TRI_BITS > BUDGET_BITS) ? TRI_BITS : BUDGET_BITS;
   localparam int A_BITS    = ITEM_BITS + 1;
   localparam int SQ_BITS   = 2 * A_BITS;
   localparam int DIFF_BITS = ((SQ_BITS > BUDGET_BITS + 3) ? SQ_BITS : BUDGET_BITS + 3) + 1;

   localparam logic [BUDGET_BITS-1:0] BUDGET_RESET = BUDGET_BITS'(65536);
   localparam logic [LIMIT_BITS-1:0]  LIMIT_RESET  = LIMIT_BITS'(63);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ELEMENT_BUDGET = 1'b0,
      CSR_SLICE_LIMIT    = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic start;
      logic step;
      logic load_slice;
      logic compare;
      logic sqrt_step;
      logic root;
      logic height;
      logic advance;
      logic load_close;
   } cmd_type;

   typedef struct packed {
      logic over_limit;
      logic fits;
      logic sqrt_last;
      logic done_rows;
      logic slot_free;
   } status_type;

endpackage
`default_nettype wire

FILE: design/triangular_slice_planner_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// triangular_slice_planner_unit
// Plans row slices of the upper triangle of a square matrix within an element
// budget and streams each slice start row, then the closing boundary.
//
//   channel  ports                    word
//   req      req_valid / req_stall    item_count
//   rsp      rsp_valid / rsp_stall    boundary_row, last, failed
//   csr      csr_write_enable         element_budget (0), slice_limit (1)
//
// a slice that does not fit whole takes its height from the 25-step square root loop
// reset clears the sequencer, planning position and result valid
// a stalled result word holds the sequencer in its emit state
// a new item is taken only once the last word of the previous run is loaded for hand over
// ----------------------------------------------------------------------------
module triangular_slice_planner_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [tsp_pkg::FIELD_BITS-1:0]     req_item_count,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [tsp_pkg::FIELD_BITS-1:0]          rsp_boundary_row,
   output logic                                    rsp_last,
   output logic                                    rsp_failed,
   input  wire logic                               csr_write_enable,
   input  wire logic [tsp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [tsp_pkg::BUDGET_BITS-1:0]    csr_write_data
);
   import tsp_pkg::*;

   cmd_type    cmd;
   status_type status;

   tsp_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   tsp_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_item_count   (req_item_count),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_boundary_row (rsp_boundary_row),
      .rsp_last         (rsp_last),
      .rsp_failed       (rsp_failed)
   );

endmodule
`default_nettype wire

FILE: design/tsp_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsp_controller
// Sequencer for the slice planner: walks each slice through the limit check,
// fit test, square root and height steps and hands results to the datapath.
// ----------------------------------------------------------------------------
module tsp_controller (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire tsp_pkg::status_type status,
   output logic                     req_stall,
   output tsp_pkg::cmd_type         cmd
);
   import tsp_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE    = 9'b000000001,
      S_STEP    = 9'b000000010,
      S_SLICE   = 9'b000000100,
      S_COMPARE = 9'b000001000,
      S_SQRT    = 9'b000010000,
      S_ROOT    = 9'b000100000,
      S_HEIGHT  = 9'b001000000,
      S_ADVANCE = 9'b010000000,
      S_CLOSE   = 9'b100000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = S_STEP;
            end
         end
         S_STEP: begin
            cmd.step = 1'b1;
            state_in = S_SLICE;
         end
         S_SLICE: begin
            if (status.slot_free) begin
               cmd.load_slice = 1'b1;
               state_in       = status.over_limit ? S_IDLE : S_COMPARE;
            end
         end
         S_COMPARE: begin
            cmd.compare = 1'b1;
            state_in    = status.fits ? S_CLOSE : S_SQRT;
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (status.sqrt_last) begin
               state_in = S_ROOT;
            end
         end
         S_ROOT: begin
            cmd.root = 1'b1;
            state_in = S_HEIGHT;
         end
         S_HEIGHT: begin
            cmd.height = 1'b1;
            state_in   = S_ADVANCE;
         end
         S_ADVANCE: begin
            if (status.done_rows) begin
               state_in = S_CLOSE;
            end else begin
               cmd.advance = 1'b1;
               state_in    = S_STEP;
            end
         end
         S_CLOSE: begin
            if (status.slot_free) begin
               cmd.load_close = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

FILE: design/tsp_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsp_datapath
// Planning registers, slice height arithmetic with a bit-pair square root,
// configuration registers and the result word register.
// ----------------------------------------------------------------------------
module tsp_datapath (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire tsp_pkg::cmd_type                     cmd,
   output tsp_pkg::status_type                       status,
   input  wire logic [tsp_pkg::FIELD_BITS-1:0]       req_item_count,
   input  wire logic                                 csr_write_enable,
   input  wire logic [tsp_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [tsp_pkg::BUDGET_BITS-1:0]      csr_write_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [tsp_pkg::FIELD_BITS-1:0]            rsp_boundary_row,
   output logic                                      rsp_last,
   output logic                                      rsp_failed
);
   import tsp_pkg::*;

   logic [BUDGET_BITS-1:0] budget_ff;
   logic [LIMIT_BITS-1:0]  limit_ff;

   logic [ITEM_BITS-1:0]   items_ff;
   logic [ITEM_BITS-1:0]   base_ff;
   logic [ITEM_BITS-1:0]   rows_ff;
   logic [MADE_BITS-1:0]   made_ff;

   logic [TRI_BITS-1:0]    tri_ff;
   logic [SQ_BITS-1:0]     asq_ff;
   logic [SQ_BITS-1:0]     d_ff;
   logic [SQ_BITS-1:0]     v_ff;
   logic [SQ_BITS-1:0]     res_ff;
   logic [SQ_BITS-1:0]     bit_ff;
   logic [SQ_BITS-1:0]     rr_ff;
   logic [A_BITS-1:0]      amr_ff;
   logic [ITEM_BITS-1:0]   h_ff;

   logic                   rsp_valid_ff;
   logic [FIELD_BITS-1:0]  rsp_row_ff;
   logic                   rsp_last_ff;
   logic                   rsp_failed_ff;

   logic [A_BITS-1:0]      a_val;
   logic [A_BITS-1:0]      w_plus;
   logic [SQ_BITS-1:0]     tri_prod;
   logic [SQ_BITS-1:0]     asq_prod;
   logic [DIFF_BITS-1:0]   diff;
   logic [SQ_BITS-1:0]     sum;
   logic [A_BITS-1:0]      root;
   logic [SQ_BITS-1:0]     rr_prod;
   logic [A_BITS-1:0]      hsum;
   logic [ITEM_BITS-1:0]   h_val;
   logic                   over;
   logic                   slot_free;

   // a = 2w+1
   assign a_val    = {rows_ff, 1'b1};
   assign w_plus   = A_BITS'(rows_ff) + A_BITS'(1);
   assign tri_prod = SQ_BITS'(A_BITS'(rows_ff)) * SQ_BITS'(w_plus);
   assign asq_prod = SQ_BITS'(a_val) * SQ_BITS'(a_val);
   assign diff     = DIFF_BITS'(asq_ff) - DIFF_BITS'({budget_ff, 3'b000});
   assign sum      = res_ff + bit_ff;
   assign root     = res_ff[A_BITS-1:0];
   assign rr_prod  = SQ_BITS'(root) * SQ_BITS'(root);
   assign hsum     = (rr_ff == d_ff) ? amr_ff : (amr_ff - A_BITS'(1));
   assign h_val    = (hsum[A_BITS-1:1] == '0) ? ITEM_BITS'(1) : hsum[A_BITS-1:1];
   assign over     = (made_ff > MADE_BITS'(limit_ff));
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   assign status.over_limit = over;
   assign status.fits       = (CMP_BITS'(tri_ff[TRI_BITS-1:1]) <= CMP_BITS'(budget_ff));
   assign status.sqrt_last  = bit_ff[0];
   assign status.done_rows  = (rows_ff <= h_ff);
   assign status.slot_free  = slot_free;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff <= BUDGET_RESET;
         limit_ff  <= LIMIT_RESET;
      end else if (csr_write_enable) begin
         if (csr_index_type'(csr_index) == CSR_ELEMENT_BUDGET) begin
            budget_ff <= csr_write_data;
         end
         if (csr_index_type'(csr_index) == CSR_SLICE_LIMIT) begin
            limit_ff <= csr_write_data[LIMIT_BITS-1:0];
         end
      end
   end

   // planning position
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         rows_ff <= '0;
         made_ff <= '0;
      end else if (cmd.start) begin
         base_ff <= '0;
         rows_ff <= req_item_count[ITEM_BITS-1:0];
         made_ff <= '0;
      end else if (cmd.step) begin
         made_ff <= made_ff + MADE_BITS'(1);
      end else if (cmd.advance) begin
         base_ff <= base_ff + h_ff;
         rows_ff <= rows_ff - h_ff;
      end
   end

   // height arithmetic
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         items_ff <= req_item_count[ITEM_BITS-1:0];
      end
      if (cmd.step) begin
         tri_ff <= tri_prod[TRI_BITS-1:0];
         asq_ff <= asq_prod;
      end
      if (cmd.compare) begin
         d_ff   <= diff[SQ_BITS-1:0];
         v_ff   <= diff[SQ_BITS-1:0];
         res_ff <= '0;
         bit_ff <= SQ_BITS'(1) << (SQ_BITS - 2);
      end else if (cmd.sqrt_step) begin
         if (v_ff >= sum) begin
            v_ff   <= v_ff - sum;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
      if (cmd.root) begin
         rr_ff  <= rr_prod;
         amr_ff <= a_val - root;
      end
      if (cmd.height) begin
         h_ff <= h_val;
      end
   end

   // result word
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_slice || cmd.load_close) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_slice) begin
         rsp_row_ff    <= FIELD_BITS'(base_ff);
         rsp_last_ff   <= over;
         rsp_failed_ff <= over;
      end else if (cmd.load_close) begin
         rsp_row_ff    <= FIELD_BITS'(items_ff);
         rsp_last_ff   <= 1'b1;
         rsp_failed_ff <= 1'b0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_boundary_row = rsp_row_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_failed       = rsp_failed_ff;

`ifndef SYNTHESIS
   a_load_needs_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_slice || cmd.load_close) |-> slot_free)
      else $error("result word loaded over an untaken word");

   a_height_range: assert property (@(posedge clock) disable iff (reset)
      cmd.height |=> ((h_ff != '0) && (h_ff <= rows_ff)))
      else $error("slice height out of range");

   a_made_bound: assert property (@(posedge clock) disable iff (reset)
      made_ff <= MADE_BITS'(MAX_RESULTS))
      else $error("slice count beyond bound");
`endif

endmodule
`default_nettype wire
